/* src/lsbx_pkg.sv */
// Shared types and constants for the LSB steganography payload extractor.
package lsbx_pkg;

  // Decode phases, one-hot
  typedef enum logic [6:0] {
    PH_HEADER = 7'b0000001,
    PH_MAGIC  = 7'b0000010,
    PH_EXTLEN = 7'b0000100,
    PH_EXT    = 7'b0001000,
    PH_PAYLEN = 7'b0010000,
    PH_DATA   = 7'b0100000,
    PH_DONE   = 7'b1000000
  } phase_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_EMPTY     = 2'd1,
    KIND_MAGIC_ERR = 2'd2,
    KIND_EXT_ERR   = 2'd3
  } kind_t;

  // Configuration register indexes
  localparam logic CFG_MAGIC_WORD  = 1'b0;
  localparam logic CFG_HEADER_SKIP = 1'b1;

  localparam logic [31:0] EXT_WORD  = 32'h7478742E;  // ".txt", first char in low byte
  localparam logic [31:0] EXT_LEN   = 32'd4;
  localparam logic [4:0]  BYTE_BITS = 5'd8;
  localparam logic [4:0]  WORD_LAST = 5'd31;         // index of last bit of a length word
  localparam logic [7:0]  HEADER_SKIP_RST = 8'd54;

  // One decode step's result
  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] secret_byte;
    logic       last;
  } result_t;

endpackage

/* src/lsbx_if.sv */
// Valid/ready channel interfaces for carrier bytes and decoded results.
interface lsbx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] carrier_byte;
  logic       frame_start;

  modport source (output valid, output carrier_byte, output frame_start, input ready);
  modport sink   (input valid, input carrier_byte, input frame_start, output ready);
endinterface

interface lsbx_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] secret_byte;
  logic       last;

  modport source (output valid, output result_kind, output secret_byte, output last,
                  input ready);
  modport sink   (input valid, input result_kind, input secret_byte, input last,
                  output ready);
endinterface

/* src/lsbx_core.sv */
// Frame parser: decode state registers and the one-bit-per-byte step logic.
module lsbx_core
  import lsbx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic        hidden_bit,
  input  logic        frame_start,
  input  logic [15:0] magic_word,
  input  logic [7:0]  header_skip,
  output result_t     res
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  header_count_r, header_count_nxt;
  logic [4:0]  bit_count_r, bit_count_nxt;
  logic [31:0] bit_shift_r, bit_shift_nxt;
  logic [1:0]  char_index_r, char_index_nxt;
  logic [31:0] remaining_r, remaining_nxt;
  logic        hold;
  logic [4:0]  pos;
  logic [2:0]  chars_done;

  // Next-state and result for one carrier byte
  always_comb begin
    phase_nxt        = phase_r;
    header_count_nxt = header_count_r;
    bit_count_nxt    = bit_count_r;
    bit_shift_nxt    = bit_shift_r;
    char_index_nxt   = char_index_r;
    remaining_nxt    = remaining_r;
    hold             = 1'b0;
    pos              = '0;
    chars_done       = '0;
    res.valid        = 1'b0;
    res.kind         = KIND_DATA;
    res.secret_byte  = '0;
    res.last         = 1'b0;

    if (step) begin
      // restart the frame
      if (frame_start) begin
        phase_nxt        = PH_HEADER;
        header_count_nxt = '0;
        bit_count_nxt    = '0;
        bit_shift_nxt    = '0;
        char_index_nxt   = '0;
        remaining_nxt    = '0;
      end

      // header skip; falls through to magic on the same byte once done
      if (phase_nxt == PH_HEADER) begin
        if (header_count_nxt < header_skip) begin
          header_count_nxt = header_count_nxt + 8'd1;
          hold             = 1'b1;
        end else begin
          phase_nxt      = PH_MAGIC;
          bit_count_nxt  = '0;
          bit_shift_nxt  = '0;
          char_index_nxt = '0;
        end
      end

      if (!hold) begin
        case (phase_nxt)
          PH_MAGIC, PH_EXT: begin
            pos                = {char_index_nxt, 3'b000} + bit_count_nxt;
            bit_shift_nxt[pos] = bit_shift_nxt[pos] | hidden_bit;
            bit_count_nxt      = bit_count_nxt + 5'd1;
            if (bit_count_nxt >= BYTE_BITS) begin
              bit_count_nxt  = '0;
              chars_done     = {1'b0, char_index_nxt} + 3'd1;
              char_index_nxt = chars_done[1:0];
              if (phase_nxt == PH_MAGIC) begin
                if (chars_done >= 3'd2) begin
                  if (bit_shift_nxt[15:0] != magic_word) begin
                    phase_nxt = PH_DONE;
                    res.valid = 1'b1;
                    res.kind  = KIND_MAGIC_ERR;
                    res.last  = 1'b1;
                  end else begin
                    phase_nxt = PH_EXTLEN;
                  end
                  bit_shift_nxt  = '0;
                  char_index_nxt = '0;
                end
              end else if (chars_done >= 3'd4) begin
                if (bit_shift_nxt != EXT_WORD) begin
                  phase_nxt = PH_DONE;
                  res.valid = 1'b1;
                  res.kind  = KIND_EXT_ERR;
                  res.last  = 1'b1;
                end else begin
                  phase_nxt = PH_PAYLEN;
                end
                bit_shift_nxt  = '0;
                char_index_nxt = '0;
              end
            end
          end

          PH_EXTLEN, PH_PAYLEN: begin
            bit_shift_nxt[bit_count_nxt] = bit_shift_nxt[bit_count_nxt] | hidden_bit;
            if (bit_count_nxt < WORD_LAST) begin
              bit_count_nxt = bit_count_nxt + 5'd1;
            end else begin
              bit_count_nxt = '0;
              bit_shift_nxt = '0;
              if (phase_nxt == PH_EXTLEN) begin
                char_index_nxt = '0;
                if (bit_shift_r != EXT_LEN || hidden_bit) begin
                  // length word complete and not four
                  phase_nxt = PH_DONE;
                  res.valid = 1'b1;
                  res.kind  = KIND_EXT_ERR;
                  res.last  = 1'b1;
                end else begin
                  phase_nxt = PH_EXT;
                end
              end else if (bit_shift_r[30:0] == '0 && !hidden_bit) begin
                phase_nxt = PH_DONE;
                res.valid = 1'b1;
                res.kind  = KIND_EMPTY;
                res.last  = 1'b1;
              end else begin
                remaining_nxt = {hidden_bit, bit_shift_r[30:0]};
                phase_nxt     = PH_DATA;
              end
            end
          end

          PH_DATA: begin
            pos                = {2'b00, bit_count_nxt[2:0]};
            bit_shift_nxt[pos] = bit_shift_nxt[pos] | hidden_bit;
            bit_count_nxt      = bit_count_nxt + 5'd1;
            if (bit_count_nxt >= BYTE_BITS) begin
              res.valid       = 1'b1;
              res.kind        = KIND_DATA;
              res.secret_byte = bit_shift_nxt[7:0];
              bit_count_nxt   = '0;
              bit_shift_nxt   = '0;
              remaining_nxt   = remaining_nxt - 32'd1;
              if (remaining_nxt == '0) begin
                phase_nxt = PH_DONE;
                res.last  = 1'b1;
              end
            end
          end

          default: begin
            // done: ignore bytes until the next frame start
          end
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HEADER;
      header_count_r <= '0;
      bit_count_r    <= '0;
      bit_shift_r    <= '0;
      char_index_r   <= '0;
      remaining_r    <= '0;
    end else begin
      phase_r        <= phase_nxt;
      header_count_r <= header_count_nxt;
      bit_count_r    <= bit_count_nxt;
      bit_shift_r    <= bit_shift_nxt;
      char_index_r   <= char_index_nxt;
      remaining_r    <= remaining_nxt;
    end
  end

  // A result marked last closes the frame
  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.valid && res.last) |=> phase_r == PH_DONE)
    else $error("last result did not end the frame");

  // Byte-wide phases never hold more than seven pending bits
  a_byte_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_MAGIC || phase_r == PH_EXT || phase_r == PH_DATA)
      |-> bit_count_r < BYTE_BITS)
    else $error("bit count overran a byte");

  // No hidden bits are collected during the header skip
  a_header_clean: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HEADER |-> (bit_shift_r == '0 && bit_count_r == '0))
    else $error("hidden bits collected during header");

  // Payload phase always has bytes still owed
  a_data_remaining: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> remaining_r != '0)
    else $error("payload phase with nothing remaining");

endmodule

/* src/lsb_stego_payload_extractor.sv */
// Top level: input register, frame parser, result register and config registers.
//
//   channel  | dir | transaction
//   in_ch    | in  | carrier_byte[7:0], frame_start
//   out_ch   | out | result_kind[1:0], secret_byte[7:0], last
//   cfg_*    | in  | cfg_we, cfg_index (0 magic_word, 1 header_skip), cfg_data[15:0]
//
// One carrier byte per cycle sustained while the result side is not stalled; an input
// transaction is captured in the input register, then parsed into the result register.
// rst_n is synchronous active low: parser returns to header skip, magic_word 0,
// header_skip 54. A stalled result holds the pipeline; with one byte parked in
// the input register the input side stalls too.
module lsb_stego_payload_extractor
  import lsbx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  lsbx_in_if.sink     in_ch,
  lsbx_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] magic_word_r;
  logic [7:0]  header_skip_r;
  logic        in_v_r;
  logic        in_bit_r;
  logic        in_fs_r;
  logic        out_v_r;
  kind_t       out_kind_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;
  logic        adv;
  result_t     res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_word_r  <= '0;
      header_skip_r <= HEADER_SKIP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAGIC_WORD:  magic_word_r  <= cfg_data;
        CFG_HEADER_SKIP: header_skip_r <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Parse the held byte when the result slot is free or draining
  assign adv         = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || adv;

  // Input register; only bit zero carries hidden data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_bit_r <= in_ch.carrier_byte[0];
      in_fs_r  <= in_ch.frame_start;
    end
  end

  lsbx_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (adv),
    .hidden_bit  (in_bit_r),
    .frame_start (in_fs_r),
    .magic_word  (magic_word_r),
    .header_skip (header_skip_r),
    .res         (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= res.valid;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.valid) begin
      out_kind_r <= res.kind;
      out_byte_r <= res.secret_byte;
      out_last_r <= res.last;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.result_kind = out_kind_r;
  assign out_ch.secret_byte = out_byte_r;
  assign out_ch.last        = out_last_r;

  // A parked byte is never dropped
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !adv) |=> in_v_r)
    else $error("held carrier byte lost");

  // A byte is parsed only into a free or draining result slot
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    adv |-> (!out_v_r || out_ch.ready))
    else $error("result overwritten while stalled");

  // A new result appears only after a parse step
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_v_r || out_ch.ready) ##1 out_v_r |-> $past(adv))
    else $error("result without parse step");

endmodule

/* tb/sv/tb_lsb_stego_payload_extractor.sv */
// Self-checking testbench for the LSB steganography payload extractor.
module tb_lsb_stego_payload_extractor;
  import lsbx_pkg::*;

  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transaction
  localparam int DRAIN_CYCLES   = 4;     // pipeline is two deep
  localparam int ITEM_TARGET    = 1050;

  // One decoded result as the block should report it
  typedef struct {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } stego_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  lsbx_in_if  in_ch();
  lsbx_out_if out_ch();

  lsb_stego_payload_extractor u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Decoder shadow: configuration and frame state
  logic [15:0] m_magic;
  logic [7:0]  m_skip;
  phase_t      m_phase;
  logic [7:0]  m_hdr_cnt;
  logic [4:0]  m_bits;
  logic [31:0] m_shift;
  logic [1:0]  m_chars;
  logic [31:0] m_remaining;

  stego_result_t expected_decode_q[$];

  int  errors          = 0;
  int  results_checked = 0;
  int  items_sent      = 0;
  int  frames_sent     = 0;
  int  reg_writes      = 0;
  int  holds_done      = 0;
  int  idle_cycles     = 0;
  int  bit_budget      = -1;
  bit  count_items     = 1'b1;
  bit  gaps_on         = 1'b1;
  bit  hold_req        = 1'b0;
  logic next_fs        = 1'b0;

  function automatic void restart_frame();
    m_phase     = PH_HEADER;
    m_hdr_cnt   = '0;
    m_bits      = '0;
    m_shift     = '0;
    m_chars     = '0;
    m_remaining = '0;
  endfunction

  function automatic bit abort_frame(input kind_t k, output stego_result_t r);
    m_phase = PH_DONE;
    m_bits  = '0;
    m_shift = '0;
    m_chars = '0;
    r.kind  = k;
    r.data  = 8'h00;
    r.last  = 1'b1;
    return 1'b1;
  endfunction

  // Advance the shadow decoder by one carrier byte; returns 1 when a result is due
  function automatic bit decode_carrier(input logic [7:0] cb, input logic fs,
                                        output stego_result_t r);
    logic        b;
    logic [4:0]  idx;
    logic [2:0]  n;
    logic [31:0] word;
    b = cb[0];
    r = '{KIND_DATA, 8'h00, 1'b0};
    if (fs) restart_frame();

    if (m_phase == PH_HEADER) begin
      if (m_hdr_cnt < m_skip) begin
        m_hdr_cnt = m_hdr_cnt + 8'd1;
        return 1'b0;
      end
      m_phase = PH_MAGIC;
      m_bits  = '0;
      m_shift = '0;
      m_chars = '0;
    end

    // magic and extension: bytes packed low char first
    if (m_phase == PH_MAGIC || m_phase == PH_EXT) begin
      idx     = {m_chars, m_bits[2:0]};
      m_shift = m_shift | ({31'd0, b} << idx);
      m_bits  = m_bits + 5'd1;
      if (m_bits < BYTE_BITS) return 1'b0;
      m_bits  = '0;
      n       = {1'b0, m_chars} + 3'd1;
      m_chars = n[1:0];
      if (m_phase == PH_MAGIC) begin
        if (n < 3'd2) return 1'b0;
        if (m_shift[15:0] != m_magic) return abort_frame(KIND_MAGIC_ERR, r);
        m_phase = PH_EXTLEN;
      end else begin
        if (n < 3'd4) return 1'b0;
        if (m_shift != EXT_WORD) return abort_frame(KIND_EXT_ERR, r);
        m_phase = PH_PAYLEN;
      end
      m_shift = '0;
      m_chars = '0;
      return 1'b0;
    end

    // 32-bit length words
    if (m_phase == PH_EXTLEN || m_phase == PH_PAYLEN) begin
      m_shift = m_shift | ({31'd0, b} << m_bits);
      if (m_bits < WORD_LAST) begin
        m_bits = m_bits + 5'd1;
        return 1'b0;
      end
      word    = m_shift;
      m_bits  = '0;
      m_shift = '0;
      if (m_phase == PH_EXTLEN) begin
        if (word != EXT_LEN) return abort_frame(KIND_EXT_ERR, r);
        m_phase = PH_EXT;
        m_chars = '0;
        return 1'b0;
      end
      if (word == 32'd0) begin
        m_phase = PH_DONE;
        r.kind  = KIND_EMPTY;
        r.last  = 1'b1;
        return 1'b1;
      end
      m_remaining = word;
      m_phase     = PH_DATA;
      return 1'b0;
    end

    if (m_phase == PH_DATA) begin
      idx     = {2'b00, m_bits[2:0]};
      m_shift = m_shift | ({31'd0, b} << idx);
      m_bits  = m_bits + 5'd1;
      if (m_bits < BYTE_BITS) return 1'b0;
      r.data      = m_shift[7:0];
      m_bits      = '0;
      m_shift     = '0;
      m_remaining = m_remaining - 32'd1;
      if (m_remaining == 32'd0) begin
        m_phase = PH_DONE;
        r.last  = 1'b1;
      end
      return 1'b1;
    end

    // done: ignore until frame_start
    return 1'b0;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Prediction on every accepted carrier byte; register writes update the shadow
  always @(posedge clk) begin : predict
    stego_result_t r;
    if (!rst_n) begin
      m_magic = 16'h0000;
      m_skip  = HEADER_SKIP_RST;
      restart_frame();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_MAGIC_WORD) m_magic = cfg_data;
        else m_skip = cfg_data[7:0];
      end
      if (in_ch.valid && in_ch.ready) begin
        if (decode_carrier(in_ch.carrier_byte, in_ch.frame_start, r))
          expected_decode_q.push_back(r);
      end
    end
  end

  task automatic report_field(input string name, input int exp_v, input int act_v);
    errors++;
    $display("%0t: result %0d %s mismatch, expected %0h actual %0h",
             $time, results_checked, name, exp_v, act_v);
  endtask

  // Result checking and watchdog
  always @(posedge clk) begin : result_check
    stego_result_t exp_r;
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("TB_ERROR");
        $finish;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_decode_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result kind %0h byte %0h last %0b", $time,
                   out_ch.result_kind, out_ch.secret_byte, out_ch.last);
        end else begin
          exp_r = expected_decode_q.pop_front();
          if (out_ch.result_kind !== exp_r.kind)
            report_field("result_kind", exp_r.kind, out_ch.result_kind);
          if (out_ch.secret_byte !== exp_r.data)
            report_field("secret_byte", exp_r.data, out_ch.secret_byte);
          if (out_ch.last !== exp_r.last)
            report_field("last", exp_r.last, out_ch.last);
          results_checked++;
        end
      end
    end
  end

  // Result receiver: random stalls plus an occasional long hold-off
  initial begin : result_sink
    int stall_left;
    int gap;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
        holds_done++;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          stall_left = gap - 1;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  // One carrier byte transaction; called and returns on a falling edge
  task automatic send_byte(input logic [7:0] cb);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.carrier_byte <= cb;
    in_ch.frame_start  <= next_fs;
    next_fs = 1'b0;
    do @(posedge clk); while (!in_ch.ready);
    if (count_items) items_sent++;
    @(negedge clk);
  endtask

  // Hide nbits of v, LSB first, in random carrier bytes
  task automatic send_field(input logic [31:0] v, input int nbits);
    for (int i = 0; i < nbits; i++) begin
      if (bit_budget == 0) return;
      if (bit_budget > 0) bit_budget--;
      send_byte({7'($urandom), v[i]});
    end
  endtask

  // Full frame: header, magic, extension length, extension, payload length, payload.
  // cut limits the hidden bits sent (-1: no limit).
  task automatic send_frame(input bit with_start, input int hdr, input logic [15:0] magic,
                            input logic [31:0] extlen, input logic [31:0] ext,
                            input logic [31:0] len_word, input int n_pay, input int cut);
    next_fs    = with_start;
    bit_budget = cut;
    frames_sent++;
    for (int i = 0; i < hdr; i++) send_byte(8'($urandom));
    send_field({16'h0000, magic}, 16);
    send_field(extlen, 32);
    send_field(ext, 32);
    send_field(len_word, 32);
    for (int i = 0; i < n_pay; i++) send_field(32'($urandom_range(0, 255)), 8);
    bit_budget = -1;
  endtask

  // Bytes outside any frame's reach; not counted as stimulus
  task automatic send_noise(input int n, input bit allow_start);
    count_items = 1'b0;
    for (int i = 0; i < n; i++) begin
      next_fs = allow_start && ($urandom_range(0, 7) == 0);
      send_byte(8'($urandom));
    end
    next_fs     = 1'b0;
    count_items = 1'b1;
  endtask

  // Stop sending and wait for every expected result, then let the pipeline empty
  task automatic wait_until_drained();
    in_ch.valid <= 1'b0;
    while (expected_decode_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [15:0] magic, input logic [7:0] skip);
    wait_until_drained();
    write_reg(CFG_MAGIC_WORD, magic);
    write_reg(CFG_HEADER_SKIP, {8'h00, skip});
  endtask

  // Reset values: magic 0, 54 header bytes, no frame_start on the first byte
  task automatic test_default_config();
    send_frame(1'b0, 54, 16'h0000, EXT_LEN, EXT_WORD, 32'd2, 0, -1);
    send_field(32'h00, 8);
    send_field(32'hFF, 8);
  endtask

  // Zero header skip and a zero payload length; trailing bytes ignored
  task automatic test_empty_payload();
    set_config(16'hFFFF, 8'd0);
    send_frame(1'b1, 0, 16'hFFFF, EXT_LEN, EXT_WORD, 32'd0, 0, -1);
    send_noise(5, 1'b0);
  endtask

  task automatic test_magic_mismatch();
    send_frame(1'b1, 0, 16'hFFFE, EXT_LEN, EXT_WORD, 32'd1, 1, 16);
    send_noise(4, 1'b0);
    send_frame(1'b1, 0, 16'h7FFF, EXT_LEN, EXT_WORD, 32'd1, 1, 16);
  endtask

  // Wrong extension length fails as soon as the word completes
  task automatic test_extlen_errors();
    send_frame(1'b1, 0, m_magic, 32'd5, EXT_WORD, 32'd1, 1, 48);
    send_frame(1'b1, 0, m_magic, 32'h80000004, EXT_WORD, 32'd1, 1, 48);
  endtask

  task automatic test_ext_mismatch();
    send_frame(1'b1, 0, m_magic, EXT_LEN, 32'h5478742E, 32'd1, 1, 80);
    send_frame(1'b1, 0, m_magic, EXT_LEN, 32'hF478742E, 32'd1, 1, 80);
  endtask

  // frame_start in the middle of payload and of header
  task automatic test_restart();
    set_config(16'h4D42, 8'd6);
    send_frame(1'b1, 6, 16'h4D42, EXT_LEN, EXT_WORD, 32'hFFFFFFFF, 3, -1);
    send_frame(1'b1, 3, 16'h4D42, EXT_LEN, EXT_WORD, 32'd1, 0, 0);
    send_frame(1'b1, 6, 16'h4D42, EXT_LEN, EXT_WORD, 32'd1, 1, -1);
  endtask

  task automatic test_header_extremes();
    set_config(16'h4D42, 8'd255);
    send_frame(1'b1, 255, 16'h4D42, EXT_LEN, EXT_WORD, 32'd1, 1, -1);
  endtask

  // Header skip lowered below the bytes already skipped: hidden bits start at once
  task automatic test_skip_lowered();
    set_config(16'h1234, 8'd20);
    send_frame(1'b1, 10, 16'h1234, EXT_LEN, EXT_WORD, 32'd1, 0, 0);
    wait_until_drained();
    write_reg(CFG_HEADER_SKIP, 16'd4);
    send_frame(1'b0, 0, 16'h1234, EXT_LEN, EXT_WORD, 32'd2, 2, -1);
  endtask

  // Receiver holds off while the sender keeps offering bytes
  task automatic test_backpressure();
    set_config(16'hA5C3, 8'd0);
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    send_frame(1'b1, 0, 16'hA5C3, EXT_LEN, EXT_WORD, 32'd16, 16, -1);
    gaps_on = 1'b1;
  endtask

  // Sender pauses mid-payload until all results are in
  task automatic test_sender_pause();
    send_frame(1'b1, 0, 16'hA5C3, EXT_LEN, EXT_WORD, 32'd6, 3, -1);
    wait_until_drained();
    for (int i = 0; i < 3; i++) send_field(32'($urandom_range(0, 255)), 8);
  endtask

  task automatic test_random();
    int pick;
    int hdr;
    int n;
    int next_cfg_at;
    bit with_start;
    logic [7:0]  skip;
    logic [31:0] w;
    next_cfg_at = items_sent;
    while (items_sent < ITEM_TARGET) begin
      // new settings every few hundred bytes
      if (items_sent >= next_cfg_at) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) skip = 8'($urandom_range(0, 6));
        else if (pick < 85) skip = HEADER_SKIP_RST;
        else if (pick < 97) skip = 8'($urandom_range(7, 30));
        else skip = 8'd255;
        set_config(16'($urandom), skip);
        next_cfg_at = items_sent + 250;
      end
      gaps_on    = ($urandom_range(0, 3) != 0);
      with_start = ($urandom_range(0, 19) != 0);
      hdr        = int'(m_skip);
      if ($urandom_range(0, 9) == 0) hdr = hdr + $urandom_range(0, 2) - 1;
      if (hdr < 0) hdr = 0;
      n    = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_frame(with_start, hdr, m_magic, EXT_LEN, EXT_WORD, 32'(n), n, -1);
      end else if (pick < 62) begin
        // length beyond what is sent; the next frame_start cuts it off
        w = ($urandom_range(0, 3) == 0) ? $urandom : 32'(n + $urandom_range(1, 300));
        send_frame(with_start, hdr, m_magic, EXT_LEN, EXT_WORD, w, n, -1);
      end else if (pick < 72) begin
        send_frame(with_start, hdr, m_magic ^ (16'd1 << $urandom_range(0, 15)),
                   EXT_LEN, EXT_WORD, 32'(n), n, 16);
      end else if (pick < 80) begin
        w = ($urandom_range(0, 1) == 0) ? $urandom : EXT_LEN ^ (32'd1 << $urandom_range(0, 31));
        if (w == EXT_LEN) w = w ^ 32'd1;
        send_frame(with_start, hdr, m_magic, w, EXT_WORD, 32'(n), n, 48);
      end else if (pick < 88) begin
        w = ($urandom_range(0, 3) == 0) ? $urandom : EXT_WORD ^ (32'd1 << $urandom_range(0, 31));
        if (w == EXT_WORD) w = w ^ 32'h100;
        send_frame(with_start, hdr, m_magic, EXT_LEN, w, 32'(n), n, 80);
      end else if (pick < 94) begin
        send_frame(with_start, hdr, m_magic, EXT_LEN, EXT_WORD, 32'(n), n,
                   $urandom_range(0, 112 + 8 * n));
      end else begin
        send_noise($urandom_range(1, 20), 1'b1);
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.carrier_byte = 8'h00;
    in_ch.frame_start  = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_MAGIC_WORD;
    cfg_data           = 16'h0000;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_default_config();
    test_empty_payload();
    test_magic_mismatch();
    test_extlen_errors();
    test_ext_mismatch();
    test_restart();
    test_header_extremes();
    test_skip_lowered();
    test_backpressure();
    test_sender_pause();
    test_random();

    wait_until_drained();
    $display("Checked %0d results from %0d carrier bytes in %0d frames",
             results_checked, items_sent, frames_sent);
    $display("Covered %0d register writes and %0d long receiver holds", reg_writes, holds_done);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
